/* sv/wsfd_pkg.sv */
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and codes for the WebSocket frame decoder.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  // parse phase codes
  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES    = 4'd2;
  localparam logic [3:0] EXT64_BYTES    = 4'd8;
  localparam logic [3:0] KEY_BYTES      = 4'd4;

  typedef struct packed {
    logic [3:0]  frame_opcode;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        frame_last;
    logic        was_masked;
    logic [63:0] payload_length;
    logic [3:0]  header_length;
    logic [63:0] frame_total_length;
  } result_t;

endpackage

/* sv/wsfd_parser.sv */
// ----------------------------------------------------------------------------
// wsfd_parser
// Per-byte frame header/payload parser; flags a result for the current byte.
// ----------------------------------------------------------------------------
module wsfd_parser import wsfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] rx_byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        mask_q, mask_d;
  logic [3:0]  fcnt_q, fcnt_d;
  logic [63:0] len_q, len_d;
  logic [63:0] rem_q, rem_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  mphase_q, mphase_d;
  logic [3:0]  hdr_q, hdr_d;

  logic [6:0]  len_code;
  logic [7:0]  key_byte;
  logic        hdr_done;   // header finished on this byte
  logic        res_valid;
  logic [7:0]  res_data;
  logic        res_bvalid;
  logic        res_last;

  assign len_code = rx_byte_i[6:0];

  always_comb begin
    unique case (mphase_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    opcode_d   = opcode_q;
    mask_d     = mask_q;
    fcnt_d     = fcnt_q;
    len_d      = len_q;
    rem_d      = rem_q;
    key_d      = key_q;
    mphase_d   = mphase_q;
    hdr_d      = hdr_q;
    hdr_done   = 1'b0;
    res_valid  = 1'b0;
    res_data   = 8'd0;
    res_bvalid = 1'b0;
    res_last   = 1'b0;

    unique case (phase_q)
      PH_HDR1: begin
        hdr_d  = 4'd2;
        mask_d = rx_byte_i[7];
        if (len_code == LEN_CODE_EXT16) begin
          len_d   = 64'd0;
          fcnt_d  = EXT16_BYTES;
          phase_d = PH_EXT;
        end else if (len_code == LEN_CODE_EXT64) begin
          len_d   = 64'd0;
          fcnt_d  = EXT64_BYTES;
          phase_d = PH_EXT;
        end else begin
          len_d = {57'd0, len_code};
          if (rx_byte_i[7]) begin
            fcnt_d  = KEY_BYTES;
            key_d   = 32'd0;
            phase_d = PH_KEY;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      PH_EXT: begin
        hdr_d  = hdr_q + 4'd1;
        len_d  = {len_q[55:0], rx_byte_i};
        fcnt_d = fcnt_q - 4'd1;
        if (fcnt_d == 4'd0) begin
          if (mask_q) begin
            fcnt_d  = KEY_BYTES;
            key_d   = 32'd0;
            phase_d = PH_KEY;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      PH_KEY: begin
        hdr_d  = hdr_q + 4'd1;
        key_d  = {key_q[23:0], rx_byte_i};
        fcnt_d = fcnt_q - 4'd1;
        if (fcnt_d == 4'd0) begin
          hdr_done = 1'b1;
        end
      end
      PH_DATA: begin
        res_data   = mask_q ? (rx_byte_i ^ key_byte) : rx_byte_i;
        res_bvalid = 1'b1;
        res_valid  = 1'b1;
        mphase_d   = mphase_q + 2'd1;
        rem_d      = rem_q - 64'd1;
        res_last   = (rem_d == 64'd0);
        if (res_last) begin
          phase_d = PH_HDR0;
        end
      end
      default: begin
        opcode_d = rx_byte_i[3:0];
        hdr_d    = 4'd1;
        phase_d  = PH_HDR1;
      end
    endcase

    // enter payload, or close an empty frame right here
    if (hdr_done) begin
      rem_d    = len_d;
      mphase_d = 2'd0;
      if (len_d == 64'd0) begin
        res_valid = 1'b1;
        res_last  = 1'b1;
        phase_d   = PH_HDR0;
      end else begin
        phase_d = PH_DATA;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      opcode_q <= 4'd0;
      mask_q   <= 1'b0;
      fcnt_q   <= 4'd0;
      len_q    <= 64'd0;
      rem_q    <= 64'd0;
      key_q    <= 32'd0;
      mphase_q <= 2'd0;
      hdr_q    <= 4'd0;
    end else if (take_i) begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      mask_q   <= mask_d;
      fcnt_q   <= fcnt_d;
      len_q    <= len_d;
      rem_q    <= rem_d;
      key_q    <= key_d;
      mphase_q <= mphase_d;
      hdr_q    <= hdr_d;
    end
  end

  assign res_valid_o              = res_valid;
  assign res_o.frame_opcode       = opcode_d;
  assign res_o.payload_byte       = res_data;
  assign res_o.byte_valid         = res_bvalid;
  assign res_o.frame_last         = res_last;
  assign res_o.was_masked         = mask_d;
  assign res_o.payload_length     = len_d;
  assign res_o.header_length      = hdr_d;
  assign res_o.frame_total_length = {60'd0, hdr_d} + len_d;

endmodule

/* sv/websocket_frame_decoder.sv */
// ----------------------------------------------------------------------------
// websocket_frame_decoder
// Parses a received byte stream into WebSocket frames and emits unmasked
// payload bytes with the frame's header information.
// ----------------------------------------------------------------------------
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------
//   input    | in_valid_i / in_stall_o | rx_byte_i
//   output   | out_valid_o/out_stall_i | frame_opcode_o .. frame_total_length_o
//
// One byte is taken per cycle unless stalled; a payload byte, or the last header
// byte of an empty frame, appears in the output register on the following cycle.
// Header bytes produce no transfer. The output register is the only stage, so
// input stalls exactly while a held result is stalled downstream.
// Reset returns the parser to the first header byte and empties the output.
// ----------------------------------------------------------------------------
module websocket_frame_decoder import wsfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  frame_opcode_o,
  output logic [7:0]  payload_byte_o,
  output logic        byte_valid_o,
  output logic        frame_last_o,
  output logic        was_masked_o,
  output logic [63:0] payload_length_o,
  output logic [3:0]  header_length_o,
  output logic [63:0] frame_total_length_o
);

  logic    take;
  logic    res_valid;
  result_t res;
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign take       = in_valid_i & ~in_stall_o;

  wsfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // hold while stalled, refill on a new result
  assign out_valid_d = (out_valid_q & out_stall_i) | (take & res_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign frame_opcode_o       = out_q.frame_opcode;
  assign payload_byte_o       = out_q.payload_byte;
  assign byte_valid_o         = out_q.byte_valid;
  assign frame_last_o         = out_q.frame_last;
  assign was_masked_o         = out_q.was_masked;
  assign payload_length_o     = out_q.payload_length;
  assign header_length_o      = out_q.header_length;
  assign frame_total_length_o = out_q.frame_total_length;

endmodule

/* tb/websocket_frame_decoder_checker.sv */
// ----------------------------------------------------------------------------
// websocket_frame_decoder_checker
// Watches both channels of the frame decoder, parses every accepted byte with
// an independent frame parser and compares each result transfer, field by
// field, with the oldest predicted result.
// ----------------------------------------------------------------------------
module websocket_frame_decoder_checker import wsfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [3:0]  frame_opcode_i,
  input  logic [7:0]  payload_byte_i,
  input  logic        byte_valid_i,
  input  logic        frame_last_i,
  input  logic        was_masked_i,
  input  logic [63:0] payload_length_i,
  input  logic [3:0]  header_length_i,
  input  logic [63:0] frame_total_length_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PRINT_LIMIT = 40;

  // parser state
  logic [2:0]  phase;
  logic [3:0]  opcode;
  logic        masked;
  logic [3:0]  field_left;
  logic [63:0] length_acc;
  logic [63:0] data_left;
  logic [31:0] key;
  logic [1:0]  key_index;
  logic [3:0]  header_bytes;

  result_t     expected_frames[$];
  int unsigned mismatches;

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT) $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic result_t frame_result(input logic [7:0] data, input logic valid,
                                           input logic last);
    result_t r;
    r.frame_opcode       = opcode;
    r.payload_byte       = data;
    r.byte_valid         = valid;
    r.frame_last         = last;
    r.was_masked         = masked;
    r.payload_length     = length_acc;
    r.header_length      = header_bytes;
    r.frame_total_length = length_acc + 64'(header_bytes);
    return r;
  endfunction

  // header complete: start the payload, or mark an empty frame
  task automatic header_done();
    data_left = length_acc;
    key_index = 2'd0;
    if (length_acc == 64'd0) begin
      expected_frames.push_back(frame_result(8'h00, 1'b0, 1'b1));
      phase = PH_HDR0;
    end else begin
      phase = PH_DATA;
    end
  endtask

  task automatic length_done();
    if (masked) begin
      field_left = KEY_BYTES;
      key = '0;
      phase = PH_KEY;
    end else begin
      header_done();
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [7:0] data;
    case (phase)
      PH_HDR1: begin
        header_bytes = 4'd2;
        masked = b[7];
        length_acc = '0;
        if (b[6:0] == LEN_CODE_EXT16) begin
          field_left = EXT16_BYTES;
          phase = PH_EXT;
        end else if (b[6:0] == LEN_CODE_EXT64) begin
          field_left = EXT64_BYTES;
          phase = PH_EXT;
        end else begin
          length_acc = 64'(b[6:0]);
          length_done();
        end
      end
      PH_EXT: begin
        header_bytes = header_bytes + 4'd1;
        length_acc = {length_acc[55:0], b};
        field_left = field_left - 4'd1;
        if (field_left == 4'd0) length_done();
      end
      PH_KEY: begin
        header_bytes = header_bytes + 4'd1;
        key = {key[23:0], b};
        field_left = field_left - 4'd1;
        if (field_left == 4'd0) header_done();
      end
      PH_DATA: begin
        data = b;
        if (masked) data = b ^ key[8 * (3 - int'(key_index)) +: 8];
        key_index = key_index + 2'd1;
        data_left = data_left - 64'd1;
        expected_frames.push_back(frame_result(data, 1'b1, data_left == 64'd0));
        if (data_left == 64'd0) phase = PH_HDR0;
      end
      default: begin
        opcode = b[3:0];
        header_bytes = 4'd1;
        phase = PH_HDR1;
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  task automatic check_result();
    result_t want;
    if (expected_frames.size() == 0) begin
      report_mismatch($sformatf("result transfer with none pending, payload_byte 0x%0h",
                                payload_byte_i));
      return;
    end
    want = expected_frames.pop_front();
    check_field("frame_opcode", 64'(frame_opcode_i), 64'(want.frame_opcode));
    check_field("payload_byte", 64'(payload_byte_i), 64'(want.payload_byte));
    check_field("byte_valid", 64'(byte_valid_i), 64'(want.byte_valid));
    check_field("frame_last", 64'(frame_last_i), 64'(want.frame_last));
    check_field("was_masked", 64'(was_masked_i), 64'(want.was_masked));
    check_field("payload_length", payload_length_i, want.payload_length);
    check_field("header_length", 64'(header_length_i), 64'(want.header_length));
    check_field("frame_total_length", frame_total_length_i, want.frame_total_length);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase        = PH_HDR0;
      opcode       = '0;
      masked       = 1'b0;
      field_left   = '0;
      length_acc   = '0;
      data_left    = '0;
      key          = '0;
      key_index    = '0;
      header_bytes = '0;
      mismatches   = 0;
      expected_frames.delete();
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      // older result leaves before this edge's byte is parsed
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) decode_byte(rx_byte_i);
      mismatch_count_o <= mismatches;
      pending_count_o  <= expected_frames.size();
    end
  end

endmodule

/* tb/websocket_frame_decoder_tb.sv */
// ----------------------------------------------------------------------------
// websocket_frame_decoder_tb
// Feeds the frame decoder a byte stream of back-to-back frames: a few
// directed frames (empty, masked, 64-bit length), then random frames of every
// length form, and a final frame whose length wraps the total. Both channels
// idle at random; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module websocket_frame_decoder_tb import wsfd_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_BYTES = 600;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  frame_opcode_o;
  logic [7:0]  payload_byte_o;
  logic        byte_valid_o;
  logic        frame_last_o;
  logic        was_masked_o;
  logic [63:0] payload_length_o;
  logic [3:0]  header_length_o;
  logic [63:0] frame_total_length_o;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned idle_cycles = 0;
  int unsigned bytes_sent = 0;
  bit          quiet = 1'b0;
  logic [7:0]  frame_stream[$];

  websocket_frame_decoder uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .rx_byte_i, .out_valid_o, .out_stall_i,
    .frame_opcode_o, .payload_byte_o, .byte_valid_o, .frame_last_o, .was_masked_o,
    .payload_length_o, .header_length_o, .frame_total_length_o
  );

  websocket_frame_decoder_checker frame_check (
    .clk_i, .rst_ni, .in_valid_i,
    .in_stall_i           (in_stall_o),
    .rx_byte_i,
    .out_valid_i          (out_valid_o),
    .out_stall_i,
    .frame_opcode_i       (frame_opcode_o),
    .payload_byte_i       (payload_byte_o),
    .byte_valid_i         (byte_valid_o),
    .frame_last_i         (frame_last_o),
    .was_masked_i         (was_masked_o),
    .payload_length_i     (payload_length_o),
    .header_length_i      (header_length_o),
    .frame_total_length_i (frame_total_length_o),
    .mismatch_count_o     (mismatch_count),
    .pending_count_o      (pending_count)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic append_frame(input logic [7:0] first_byte, input logic masked,
                              input len_form_e form, input logic [63:0] length,
                              input int unsigned data_count);
    logic [31:0] key;
    key = $urandom;
    frame_stream.push_back(first_byte);
    case (form)
      LEN_SHORT: frame_stream.push_back({masked, length[6:0]});
      LEN_EXT16: begin
        frame_stream.push_back({masked, LEN_CODE_EXT16});
        frame_stream.push_back(length[15:8]);
        frame_stream.push_back(length[7:0]);
      end
      default: begin
        frame_stream.push_back({masked, LEN_CODE_EXT64});
        for (int i = 7; i >= 0; i--) frame_stream.push_back(length[8 * i +: 8]);
      end
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) frame_stream.push_back(key[8 * i +: 8]);
    end
    repeat (data_count) frame_stream.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic append_random_frame();
    int unsigned pick;
    logic [63:0] length;
    len_form_e   form;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      form = LEN_SHORT;
      length = ($urandom_range(0, 49) == 0) ? 64'd125 : 64'($urandom_range(0, 10));
    end else if (pick < 85) begin
      form = LEN_EXT16;
      length = ($urandom_range(0, 29) == 0) ? 64'($urandom_range(256, 300))
                                            : 64'($urandom_range(0, 12));
    end else begin
      form = LEN_EXT64;
      length = ($urandom_range(0, 29) == 0) ? 64'($urandom_range(256, 280))
                                            : 64'($urandom_range(0, 12));
    end
    append_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), form, length,
                 int'(length));
  endtask

  // hold each byte until its transfer, with random gaps between bytes
  task automatic send_stream();
    int unsigned gap;
    while (frame_stream.size() != 0) begin
      gap = quiet ? 0 : pick_gap();
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      rx_byte_i  <= frame_stream.pop_front();
      do @(posedge clk_i); while (in_stall_o);
      bytes_sent++;
      quiet = ((bytes_sent / 128) % 5) == 3;
    end
    in_valid_i <= 1'b0;
  endtask

  // downstream stalls
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      n = pick_gap();
      if (n != 0 && !quiet) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("websocket_frame_decoder regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty frames, unmasked and masked; masked payload wrapping the key
    append_frame(8'h81, 1'b0, LEN_SHORT, 64'd0, 0);
    append_frame(8'hFF, 1'b1, LEN_SHORT, 64'd0, 0);
    append_frame(8'h00, 1'b1, LEN_SHORT, 64'd5, 5);
    // non-minimal 64-bit encoding of an empty frame
    append_frame(8'h72, 1'b0, LEN_EXT64, 64'd0, 0);
    send_stream();

    // drain everything before the random part
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);

    while (frame_stream.size() < RANDOM_BYTES) append_random_frame();
    // top length bit set: total wraps, frame left open at the end of the run
    append_frame(8'h88, 1'b1, LEN_EXT64, 64'hFFFF_FFFF_FFFF_FFF6, 12);
    send_stream();

    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("websocket_frame_decoder regression: pass");
    end else begin
      $display("websocket_frame_decoder regression: fail");
    end
    $finish;
  end

endmodule
